[src/fic_pkg.sv]
// Package for the firmware image checker: parse phases, status codes and the result item type.
`timescale 1ns / 1ps
`default_nettype none
package fic_pkg;

  localparam int PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_IDLE     = 4'd0;
  localparam logic [PhaseW-1:0] PH_HDR1     = 4'd1;
  localparam logic [PhaseW-1:0] PH_SKIPHDR  = 4'd2;
  localparam logic [PhaseW-1:0] PH_SKIPDATA = 4'd3;
  localparam logic [PhaseW-1:0] PH_HDR2     = 4'd4;
  localparam logic [PhaseW-1:0] PH_SECHDR   = 4'd5;
  localparam logic [PhaseW-1:0] PH_DATA     = 4'd6;
  localparam logic [PhaseW-1:0] PH_CSUM     = 4'd7;
  localparam logic [PhaseW-1:0] PH_DONE     = 4'd8;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_FW      = 3'd1;
  localparam logic [2:0] ST_BAD_SECHDR = 3'd2;
  localparam logic [2:0] ST_BAD_MAP    = 3'd3;
  localparam logic [2:0] ST_BAD_CSUM   = 3'd4;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0] MAGIC_HDR1 = 8'hEA;
  localparam logic [7:0] MAGIC_HDR2 = 8'hE9;
  localparam logic [7:0] XOR_SEED   = 8'hEF;
  localparam logic [7:0] MAP_ANY    = 8'hFF;
  localparam logic [3:0] MAP_ALT    = 4'd2;

  localparam logic CFG_REQUIRED_MAP = 1'b0;
  localparam logic CFG_MAP_CHECK_EN = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] load_address;
    logic [7:0]  load_data;
    logic [2:0]  status;
    logic [31:0] boot_address;
    logic [3:0]  image_map;
    logic [3:0]  image_mode;
  } fic_result_t;

endpackage
`default_nettype wire

[src/fic_parser.sv]
// Image parser: header and section state, checksum, and the result, if any, for each accepted byte.
`timescale 1ns / 1ps
`default_nettype none
module fic_parser
  import fic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_of_image,
  input  wire logic [7:0]  required_map,
  input  wire logic        map_check_enable,
  output logic             res_valid,
  output fic_result_t      res
);

  logic [PhaseW-1:0] phase;
  logic [31:0] byte_pos;
  logic [2:0]  field_idx;
  logic [7:0]  sections_left;
  logic [31:0] bytes_left;
  logic [31:0] ram_address;
  logic [7:0]  running_xor;
  logic [31:0] entry_address;
  logic [3:0]  map_nibble;
  logic [3:0]  mode_nibble;
  logic [31:0] csum_offset;

  logic [PhaseW-1:0] phase_next;
  logic [31:0] byte_pos_next;
  logic [2:0]  field_idx_next;
  logic [7:0]  sections_left_next;
  logic [31:0] bytes_left_next;
  logic [31:0] ram_address_next;
  logic [7:0]  running_xor_next;
  logic [31:0] entry_address_next;
  logic [3:0]  map_nibble_next;
  logic [3:0]  mode_nibble_next;
  logic [31:0] csum_offset_next;

  // current view of the state, with a start restoring the cleared values
  logic [PhaseW-1:0] ph_c;
  logic [31:0] pos_c;
  logic [2:0]  idx_c;
  logic [7:0]  sec_c;
  logic [31:0] left_c;
  logic [31:0] addr_c;
  logic [7:0]  xor_c;
  logic [31:0] entry_c;
  logic [3:0]  map_c;
  logic [3:0]  mode_c;
  logic [31:0] csum_c;

  logic        hdr;
  logic        verdict;
  logic [2:0]  verdict_st;
  logic        map_bad;
  logic [7:0]  sec_dec;

  function automatic logic [31:0] put_lane(logic [31:0] w, logic [1:0] lane, logic [7:0] b);
    logic [31:0] r;
    r = w;
    unique case (lane)
      2'd0: r[7:0]   = b;
      2'd1: r[15:8]  = b;
      2'd2: r[23:16] = b;
      2'd3: r[31:24] = b;
      default: r = w;
    endcase
    return r;
  endfunction

  always_comb begin
    if (start_of_image) begin
      ph_c = PH_HDR1;  pos_c = '0;  idx_c = '0;  sec_c = '0;  left_c = '0;
      addr_c = '0;  xor_c = XOR_SEED;  entry_c = '0;  map_c = '0;  mode_c = '0;
      csum_c = '0;
    end else begin
      ph_c = phase;  pos_c = byte_pos;  idx_c = field_idx;  sec_c = sections_left;
      left_c = bytes_left;  addr_c = ram_address;  xor_c = running_xor;
      entry_c = entry_address;  map_c = map_nibble;  mode_c = mode_nibble;
      csum_c = csum_offset;
    end

    phase_next         = ph_c;
    byte_pos_next      = pos_c + 32'd1;
    field_idx_next     = idx_c;
    sections_left_next = sec_c;
    bytes_left_next    = left_c;
    ram_address_next   = addr_c;
    running_xor_next   = xor_c;
    entry_address_next = entry_c;
    map_nibble_next    = map_c;
    mode_nibble_next   = mode_c;
    csum_offset_next   = csum_c;

    hdr        = 1'b0;
    verdict    = 1'b0;
    verdict_st = ST_OK;
    map_bad    = 1'b0;
    sec_dec    = sec_c - 8'd1;
    res_valid  = 1'b0;
    res        = '0;

    unique case (ph_c)
      PH_IDLE, PH_DONE: begin
        byte_pos_next = pos_c;
      end
      PH_HDR1: begin
        hdr = 1'b1;
        if (idx_c == 3'd0 && data_byte != MAGIC_HDR1) begin
          verdict = 1'b1;  verdict_st = ST_NO_FW;
        end else if (idx_c == 3'd1 && data_byte == 8'd0) begin
          verdict = 1'b1;  verdict_st = ST_NO_FW;
        end else if (idx_c == 3'd7) begin
          phase_next = PH_SKIPHDR;
        end
      end
      PH_SKIPHDR: begin
        hdr = 1'b1;
        if (idx_c[2]) begin
          // lanes above the current one were cleared on the first length byte
          bytes_left_next = put_lane((idx_c == 3'd4) ? 32'd0 : left_c, idx_c[1:0], data_byte);
        end
        if (idx_c == 3'd7)
          phase_next = (bytes_left_next != 32'd0) ? PH_SKIPDATA : PH_HDR2;
      end
      PH_SKIPDATA: begin
        bytes_left_next = left_c - 32'd1;
        if (left_c == 32'd1) phase_next = PH_HDR2;
      end
      PH_HDR2: begin
        hdr = 1'b1;
        if (idx_c == 3'd2) mode_nibble_next = data_byte[3:0];
        if (idx_c == 3'd3) map_nibble_next = data_byte[7:4];
        map_bad = map_check_enable && required_map != MAP_ANY &&
                  {4'd0, map_nibble_next} != required_map &&
                  !(map_nibble_next == MAP_ALT && required_map == 8'd0);
        if (idx_c[2])
          entry_address_next = put_lane((idx_c == 3'd4) ? 32'd0 : entry_c, idx_c[1:0],
                                        data_byte);
        if (idx_c == 3'd0 && data_byte != MAGIC_HDR2) begin
          verdict = 1'b1;  verdict_st = ST_BAD_SECHDR;
        end else if (idx_c == 3'd1 && data_byte == 8'd0) begin
          verdict = 1'b1;  verdict_st = ST_BAD_SECHDR;
        end else if (idx_c == 3'd3 && map_bad) begin
          verdict = 1'b1;  verdict_st = ST_BAD_MAP;
        end else begin
          if (idx_c == 3'd1) sections_left_next = data_byte;
          if (idx_c == 3'd7) phase_next = PH_SECHDR;
        end
      end
      PH_SECHDR: begin
        hdr = 1'b1;
        if (!idx_c[2])
          ram_address_next = put_lane((idx_c == 3'd0) ? 32'd0 : addr_c, idx_c[1:0], data_byte);
        else
          bytes_left_next = put_lane((idx_c == 3'd4) ? 32'd0 : left_c, idx_c[1:0], data_byte);
        if (idx_c == 3'd7) begin
          if (bytes_left_next == 32'd0) begin
            sections_left_next = sec_dec;
            if (sec_dec == 8'd0) begin
              csum_offset_next = byte_pos_next | 32'h0000_000F;
              phase_next       = PH_CSUM;
            end else begin
              phase_next = PH_SECHDR;
            end
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res_valid        = 1'b1;
        res.kind         = KIND_LOAD;
        res.load_address = addr_c;
        res.load_data    = data_byte;
        running_xor_next = xor_c ^ data_byte;
        ram_address_next = addr_c + 32'd1;
        bytes_left_next  = left_c - 32'd1;
        if (left_c == 32'd1) begin
          sections_left_next = sec_dec;
          if (sec_dec == 8'd0) begin
            csum_offset_next = byte_pos_next | 32'h0000_000F;
            phase_next       = PH_CSUM;
          end else begin
            phase_next = PH_SECHDR;
          end
        end
      end
      PH_CSUM: begin
        if (pos_c == csum_c) begin
          verdict    = 1'b1;
          verdict_st = (data_byte == xor_c) ? ST_OK : ST_BAD_CSUM;
        end
      end
      default: begin
        phase_next    = PH_IDLE;
        byte_pos_next = pos_c;
      end
    endcase

    if (hdr) field_idx_next = idx_c + 3'd1;

    if (verdict) begin
      phase_next       = PH_DONE;
      res_valid        = 1'b1;
      res.kind         = KIND_VERDICT;
      res.status       = verdict_st;
      res.boot_address = (verdict_st == ST_OK) ? entry_c : 32'd0;
      res.image_map    = map_nibble_next;
      res.image_mode   = mode_nibble_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_pos      <= byte_pos_next;
      field_idx     <= field_idx_next;
      sections_left <= sections_left_next;
      bytes_left    <= bytes_left_next;
      ram_address   <= ram_address_next;
      running_xor   <= running_xor_next;
      entry_address <= entry_address_next;
      map_nibble    <= map_nibble_next;
      mode_nibble   <= mode_nibble_next;
      csum_offset   <= csum_offset_next;
    end
  end

endmodule
`default_nettype wire

[src/firmware_image_checker.sv]
// Top level of the firmware image checker: configuration registers, parser and result register.
//
// Usage: image bytes enter on the input channel (in_valid/in_stall) in flash
// order, start_of_image set on the first byte of each image. Each accepted
// item gives at most one result item on the output channel
// (out_valid/out_stall): a load write (result_kind 0) for every section data
// byte, or a single verdict (result_kind 1) that ends the image. Bytes after
// the verdict, or before any start, are dropped silently.
// A result is loaded into the output register on the edge that accepts its
// byte and is offered in the next cycle. Throughput is one byte per cycle,
// set by the single parser stage; a byte is taken whenever the output
// register is empty or being emptied in the same cycle.
// While the receiver stalls with a result pending, in_stall is raised and the
// parser holds its state. Reset (rst, synchronous) empties the output register,
// sets the parser idle, required_map to 255 and map_check_enable to 1.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect on the
// next edge and must only be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module firmware_image_checker
  import fic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_of_image,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [31:0]      load_address,
  output logic [7:0]       load_data,
  output logic [2:0]       status,
  output logic [31:0]      boot_address,
  output logic [3:0]       image_map,
  output logic [3:0]       image_mode
);

  logic [7:0]  required_map;
  logic        map_check_enable;
  logic        accept;
  logic        res_valid;
  fic_result_t res;
  fic_result_t out_q;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      required_map     <= MAP_ANY;
      map_check_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_REQUIRED_MAP: required_map     <= cfg_data;
        CFG_MAP_CHECK_EN: map_check_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fic_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .data_byte        (data_byte),
    .start_of_image   (start_of_image),
    .required_map     (required_map),
    .map_check_enable (map_check_enable),
    .res_valid        (res_valid),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) out_q <= res;
  end

  assign result_kind  = out_q.kind;
  assign load_address = out_q.load_address;
  assign load_data    = out_q.load_data;
  assign status       = out_q.status;
  assign boot_address = out_q.boot_address;
  assign image_map    = out_q.image_map;
  assign image_mode   = out_q.image_mode;

endmodule
`default_nettype wire
